>>> rtl/cfcrc_pkg.sv
package cfcrc_pkg;

  // CRC-8 with the SAE J1850 parameters, processed MSB first
  localparam logic [7:0] CRC_POLY    = 8'h1D;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_XOROUT  = 8'hFF;
  localparam logic [7:0] COOLANT_OFS = 8'd40;

  typedef enum logic {
    FUNC_PACK   = 1'b0,
    FUNC_UNPACK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_VEHICLE = 2'd0,
    KIND_DIAG    = 2'd1,
    KIND_ENGINE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic              func;
    logic [1:0]        msg_kind;
    logic [63:0]       frame_in;
    logic [15:0]       word_first;
    logic [15:0]       word_second;
    logic [2:0]        vehicle_mode;
    logic [4:0]        flag_bits;
    logic [7:0]        small_byte;
    logic [7:0]        extra_byte;
    logic signed [7:0] coolant_temp;
    logic [7:0]        alive_count;
  } codec_in_t;

  typedef struct packed {
    logic              crc_ok;
    logic [63:0]       frame_out;
    logic [15:0]       got_word_first;
    logic [15:0]       got_word_second;
    logic [2:0]        got_vehicle_mode;
    logic [4:0]        got_flag_bits;
    logic [7:0]        got_small_byte;
    logic [7:0]        got_extra_byte;
    logic signed [7:0] got_coolant_temp;
    logic [7:0]        got_alive_count;
  } codec_out_t;

  // Fold one payload byte into the running CRC register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/can_frame_crc8_signal_codec_unit.sv
// CAN payload codec: each beat either packs signal values into an 8-byte
// payload (alive counter in byte 6, CRC-8 poly 0x1D / init 0xFF / xorout 0xFF
// over bytes 0..6 in byte 7) or unpacks a received payload and checks its CRC,
// returning all-zero signals and crc_ok low on a mismatch or an unknown kind.
// Throughput is one beat per cycle while the output is not stalled. A beat
// passes through four register stages in order: payload assembly, CRC over
// bytes 0..2, CRC over bytes 3..6, then compare/decode into the output
// register. Each stage has its own valid bit, and bubbles are squeezed out
// under back-pressure.
module can_frame_crc8_signal_codec_unit
  import cfcrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  codec_in_t  in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output codec_out_t out_o
);

  // Stage control flags
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy_out;

  // Per-stage payload
  logic        s1_unpack_q, s2_unpack_q, s3_unpack_q;
  logic        s1_kind_ok_q, s2_kind_ok_q, s3_kind_ok_q;
  logic [1:0]  s1_kind_q, s2_kind_q, s3_kind_q;
  logic [63:0] s1_frame_q, s2_frame_q, s3_frame_q;
  logic [7:0]  s2_crc_q, s3_crc_q;
  codec_out_t  out_q;

  logic [63:0] pack_frame;
  logic [63:0] s1_frame_d;
  logic [7:0]  s2_crc_d, s3_crc_d;
  codec_out_t  out_d;

  // Ready ripples back from the output; an empty stage always takes a beat
  assign rdy_out    = !out_valid_q || out_ready_i;
  assign rdy3       = !s3_valid_q || rdy_out;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_ready_o = rdy1;

  // Assemble the packed payload bytes 0..6 for the input kind
  always_comb begin
    pack_frame        = '0;
    pack_frame[15:0]  = in_i.word_first;
    pack_frame[31:16] = in_i.word_second;
    case (in_i.msg_kind)
      KIND_VEHICLE: begin
        pack_frame[7:0]   = {in_i.flag_bits, in_i.vehicle_mode};
        pack_frame[23:8]  = in_i.word_first;
        pack_frame[31:24] = {4'b0000, in_i.small_byte[3:0]};
        pack_frame[47:32] = in_i.word_second;
      end
      KIND_DIAG: begin
        pack_frame[39:32] = in_i.small_byte;
        pack_frame[47:40] = in_i.extra_byte;
      end
      KIND_ENGINE: begin
        pack_frame[39:32] = in_i.coolant_temp + COOLANT_OFS;
        pack_frame[47:40] = {7'b0000000, in_i.flag_bits[0]};
      end
      default: begin
        pack_frame = '0;
      end
    endcase
    pack_frame[55:48] = in_i.alive_count;
    s1_frame_d = (in_i.func == FUNC_UNPACK) ? in_i.frame_in : pack_frame;
  end

  // CRC over bytes 0..2, then bytes 3..6 with the final xor
  always_comb begin
    s2_crc_d = CRC_INIT;
    for (int i = 0; i < 3; i++) begin
      s2_crc_d = crc8_byte(s2_crc_d, s1_frame_q[8*i +: 8]);
    end
    s3_crc_d = s2_crc_q;
    for (int i = 3; i < 7; i++) begin
      s3_crc_d = crc8_byte(s3_crc_d, s2_frame_q[8*i +: 8]);
    end
    s3_crc_d = s3_crc_d ^ CRC_XOROUT;
  end

  // Compare and decode into the result beat
  always_comb begin
    out_d = '0;
    if (s3_kind_ok_q) begin
      if (!s3_unpack_q) begin
        out_d.crc_ok    = 1'b1;
        out_d.frame_out = {s3_crc_q, s3_frame_q[55:0]};
      end else if (s3_frame_q[63:56] == s3_crc_q) begin
        out_d.crc_ok          = 1'b1;
        out_d.got_alive_count = s3_frame_q[55:48];
        out_d.got_word_first  = s3_frame_q[15:0];
        out_d.got_word_second = s3_frame_q[31:16];
        case (s3_kind_q)
          KIND_VEHICLE: begin
            out_d.got_vehicle_mode = s3_frame_q[2:0];
            out_d.got_flag_bits    = s3_frame_q[7:3];
            out_d.got_word_first   = s3_frame_q[23:8];
            out_d.got_small_byte   = {4'b0000, s3_frame_q[27:24]};
            out_d.got_word_second  = s3_frame_q[47:32];
          end
          KIND_DIAG: begin
            out_d.got_small_byte = s3_frame_q[39:32];
            out_d.got_extra_byte = s3_frame_q[47:40];
          end
          KIND_ENGINE: begin
            out_d.got_coolant_temp = s3_frame_q[39:32] - COOLANT_OFS;
            out_d.got_flag_bits    = {4'b0000, s3_frame_q[40]};
          end
          default: begin
            out_d = '0;
          end
        endcase
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_valid_i;
      if (rdy2) s2_valid_q <= s1_valid_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
      if (rdy_out) out_valid_q <= s3_valid_q;
    end
  end

  // Advance stage payloads; hold when the next stage is stalled
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_unpack_q  <= (in_i.func == FUNC_UNPACK);
      s1_kind_q    <= in_i.msg_kind;
      s1_kind_ok_q <= (in_i.msg_kind == KIND_VEHICLE) || (in_i.msg_kind == KIND_DIAG) ||
                      (in_i.msg_kind == KIND_ENGINE);
      s1_frame_q   <= s1_frame_d;
    end
    if (rdy2 && s1_valid_q) begin
      s2_unpack_q  <= s1_unpack_q;
      s2_kind_q    <= s1_kind_q;
      s2_kind_ok_q <= s1_kind_ok_q;
      s2_frame_q   <= s1_frame_q;
      s2_crc_q     <= s2_crc_d;
    end
    if (rdy3 && s2_valid_q) begin
      s3_unpack_q  <= s2_unpack_q;
      s3_kind_q    <= s2_kind_q;
      s3_kind_ok_q <= s2_kind_ok_q;
      s3_frame_q   <= s2_frame_q;
      s3_crc_q     <= s3_crc_d;
    end
    if (rdy_out && s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> verif/tb_can_frame_crc8_signal_codec_unit.sv
module tb_can_frame_crc8_signal_codec_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcrc_pkg::*;

  // Message kind code that the package leaves undefined
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  codec_in_t  in_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  codec_out_t out_o;

  int idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  codec_out_t expected_results[$];
  codec_out_t oldest_result;

  always #1 clk_i = ~clk_i;

  can_frame_crc8_signal_codec_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // CRC-8, MSB first, over payload bytes 0..6 (byte 0 in the low bits)
  function automatic logic [7:0] j1850_crc(input logic [55:0] payload);
    logic [7:0] acc;
    int         i;
    int         k;
    acc = CRC_INIT;
    for (i = 0; i < 7; i++) begin
      acc = acc ^ payload[8*i +: 8];
      for (k = 0; k < 8; k++) begin
        if (acc[7]) begin
          acc = {acc[6:0], 1'b0} ^ CRC_POLY;
        end else begin
          acc = {acc[6:0], 1'b0};
        end
      end
    end
    return acc ^ CRC_XOROUT;
  endfunction

  // Append the matching CRC byte to a 7-byte payload
  function automatic logic [63:0] sealed_frame(input logic [55:0] body);
    return {j1850_crc(body), body};
  endfunction

  // Expected result beat for one request beat
  function automatic codec_out_t codec_result(input codec_in_t x);
    codec_out_t r;
    logic [55:0] body;
    logic [7:0]  cool_code;
    r = '0;
    body = '0;
    if (x.msg_kind == KIND_RESERVED) begin
      return r;
    end
    if (x.func == FUNC_PACK) begin
      cool_code = x.coolant_temp + COOLANT_OFS;
      case (x.msg_kind)
        KIND_VEHICLE: begin
          body[47:0] = {x.word_second, 4'b0, x.small_byte[3:0], x.word_first,
                        x.flag_bits, x.vehicle_mode};
        end
        KIND_DIAG: begin
          body[47:0] = {x.extra_byte, x.small_byte, x.word_second, x.word_first};
        end
        default: begin
          body[47:0] = {7'b0, x.flag_bits[0], cool_code, x.word_second, x.word_first};
        end
      endcase
      body[55:48] = x.alive_count;
      r.crc_ok = 1'b1;
      r.frame_out = sealed_frame(body);
      return r;
    end
    // Unpack: decode only when the CRC byte matches
    body = x.frame_in[55:0];
    if (x.frame_in[63:56] != j1850_crc(body)) begin
      return r;
    end
    r.crc_ok = 1'b1;
    r.got_alive_count = body[55:48];
    case (x.msg_kind)
      KIND_VEHICLE: begin
        r.got_vehicle_mode = body[2:0];
        r.got_flag_bits    = body[7:3];
        r.got_word_first   = body[23:8];
        r.got_small_byte   = {4'b0, body[27:24]};
        r.got_word_second  = body[47:32];
      end
      KIND_DIAG: begin
        r.got_word_first  = body[15:0];
        r.got_word_second = body[31:16];
        r.got_small_byte  = body[39:32];
        r.got_extra_byte  = body[47:40];
      end
      default: begin
        r.got_word_first   = body[15:0];
        r.got_word_second  = body[31:16];
        r.got_coolant_temp = body[39:32] - COOLANT_OFS;
        r.got_flag_bits    = {4'b0, body[40]};
      end
    endcase
    return r;
  endfunction

  function automatic codec_in_t blank_request(input logic func, input logic [1:0] kind);
    codec_in_t it;
    it = '0;
    it.func = func;
    it.msg_kind = kind;
    return it;
  endfunction

  // Random request: mostly well-sealed frames, some with a flipped bit, some noise
  function automatic codec_in_t random_request();
    codec_in_t   it;
    logic [55:0] body;
    int          pick;
    it.func         = 1'($urandom_range(1));
    it.msg_kind     = ($urandom_range(99) < 6) ? KIND_RESERVED : 2'($urandom_range(2));
    it.word_first   = 16'($urandom);
    it.word_second  = 16'($urandom);
    it.vehicle_mode = 3'($urandom);
    it.flag_bits    = 5'($urandom);
    it.small_byte   = 8'($urandom);
    it.extra_byte   = 8'($urandom);
    it.coolant_temp = 8'($urandom);
    it.alive_count  = 8'($urandom);
    body = {24'($urandom), 32'($urandom)};
    pick = $urandom_range(99);
    if (pick < 70) begin
      it.frame_in = sealed_frame(body);
    end else if (pick < 85) begin
      it.frame_in = sealed_frame(body) ^ (64'd1 << $urandom_range(63));
    end else begin
      it.frame_in = {32'($urandom), 32'($urandom)};
    end
    return it;
  endfunction

  // Drive one request beat, idling first at random, and hold it until taken
  task automatic send_beat(input codec_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    expected_results.push_back(codec_result(item));
    beats_sent++;
  endtask

  task automatic test_pack_extremes();
    codec_in_t it;
    int        k;
    for (k = 0; k < 4; k++) begin
      send_beat(blank_request(FUNC_PACK, 2'(k)));
      if (k < 3) begin
        it = '1;
        it.func = FUNC_PACK;
        it.msg_kind = 2'(k);
        it.coolant_temp = 8'sd127;
        send_beat(it);
      end
    end
  endtask

  task automatic test_unpack_crc();
    codec_in_t it;
    int        k;
    for (k = 0; k < 4; k++) begin
      it = blank_request(FUNC_UNPACK, 2'(k));
      it.frame_in = sealed_frame('0);
      send_beat(it);
      it.frame_in = sealed_frame('1);
      send_beat(it);
      // corrupt the CRC byte
      if (k < 3) begin
        it.frame_in = sealed_frame('1) ^ {8'h01, 56'h0};
        send_beat(it);
      end
    end
  endtask

  task automatic test_coolant_wrap();
    codec_in_t it;
    it = blank_request(FUNC_PACK, KIND_ENGINE);
    it.coolant_temp = -8'sd1;
    send_beat(it);
    it.coolant_temp = -8'sd40;
    send_beat(it);
    it.coolant_temp = -8'sd128;
    send_beat(it);
    // received temperature codes at both ends of the byte
    it = blank_request(FUNC_UNPACK, KIND_ENGINE);
    it.frame_in = sealed_frame({8'hA5, 8'h01, 8'h00, 16'h0BB8, 16'h1234});
    send_beat(it);
    it.frame_in = sealed_frame({8'h5A, 8'h00, 8'hFF, 16'hFFFF, 16'h0000});
    send_beat(it);
  endtask

  task automatic test_random_traffic(input int count, input int sender_idle,
                                     input int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) begin
      send_beat(random_request());
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Randomly stall the result side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result beat with the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request pending");
        mismatch_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("crc_ok", 64'(oldest_result.crc_ok), 64'(out_o.crc_ok));
        check_field("frame_out", oldest_result.frame_out, out_o.frame_out);
        check_field("got_word_first", 64'(oldest_result.got_word_first),
                    64'(out_o.got_word_first));
        check_field("got_word_second", 64'(oldest_result.got_word_second),
                    64'(out_o.got_word_second));
        check_field("got_vehicle_mode", 64'(oldest_result.got_vehicle_mode),
                    64'(out_o.got_vehicle_mode));
        check_field("got_flag_bits", 64'(oldest_result.got_flag_bits),
                    64'(out_o.got_flag_bits));
        check_field("got_small_byte", 64'(oldest_result.got_small_byte),
                    64'(out_o.got_small_byte));
        check_field("got_extra_byte", 64'(oldest_result.got_extra_byte),
                    64'(out_o.got_extra_byte));
        check_field("got_coolant_temp", 64'($unsigned(oldest_result.got_coolant_temp)),
                    64'($unsigned(out_o.got_coolant_temp)));
        check_field("got_alive_count", 64'(oldest_result.got_alive_count),
                    64'(out_o.got_alive_count));
        results_checked++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_pack_extremes();
    test_unpack_crc();
    test_coolant_wrap();
    test_random_traffic(375, 0, 0);
    test_random_traffic(375, 49, 0);
    test_random_traffic(375, 0, 49);
    test_random_traffic(375, 20, 20);
    in_valid_i <= 1'b0;

    // Drain the pipeline, then watch for stray beats
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: pack and unpack of all message kinds, reserved kind,",
             beats_sent);
    $display("good and broken CRCs, coolant wrap; %0d results checked under four pacings",
             results_checked);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cfcrc_pkg.sv
rtl/can_frame_crc8_signal_codec_unit.sv
verif/tb_can_frame_crc8_signal_codec_unit.sv
